// ----- rtl/dtoi_pkg.sv -----
// Shared types, codes and helpers of the decimal text to int32 parser.
// No dependencies; used by every module of the block.
package dtoi_pkg;

  localparam int CHAR_W   = 8;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 3;
  localparam int ACC_W    = VAL_W + 4;
  localparam int OUT_W    = 40;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STAT_W-1:0] ST_INVALID   = 3'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd4;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [ACC_W-1:0] POS_LIMIT = 36'd2147483647;
  localparam logic [ACC_W-1:0] NEG_LIMIT = 36'd2147483648;

  localparam logic [VAL_W-1:0] SENTINEL_RST = 32'h8000_0000;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SIGN   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_TRAIL  = 3'd3,
    PH_ERROR  = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic               neg;
    logic [VAL_W-1:0]   mag;
    logic [STAT_W-1:0]  err;
  } parse_state_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [STAT_W-1:0]       status;
    logic                    hit;
  } result_t;

  localparam parse_state_t PARSE_RST = '{phase: PH_LEAD, neg: 1'b0, mag: '0, err: ST_OK};

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// ----- rtl/decimal_text_to_int32_parser.sv -----
// Top level of the decimal text to int32 parser: input register, parse state,
// result register and sentinel register. Depends on dtoi_pkg, dtoi_step, dtoi_result.
//
// Usage:
//   in_*  : one ASCII character per transaction in in_tdata[7:0]. A zero byte
//           ends the string and produces exactly one result; every other
//           character produces none.
//   out_* : one result per string, out_tdata = {4'b0, sentinel_hit, status,
//           parsed_value}. Status 0 ok, 1 empty, 2 invalid, 3 overflow,
//           4 underflow; the value is zero for any status other than ok.
//   cfg_* : writes the 32-bit sentinel. A successful value equal to it comes
//           out as sentinel + 1 with sentinel_hit set. cfg_ready is always high.
// Path: a character is captured in the input register and parsed from there
//   into the parse state; a terminator's result then moves from the input
//   register into the output register.
// Throughput: one character per cycle while no terminator stalls. The parse state
//   update (multiply by ten via shift-add, plus a 36-bit bound compare) is combinational.
// Stall: characters keep flowing while a result waits; only a terminator that
//   finds the output register still full holds in the input register, and
//   in_tready drops until out_tready frees the slot.
// Reset: rst_n low (synchronous) clears all parse state, empties both
//   registers and loads the sentinel with -2147483648. After each terminator
//   the parse state returns to that reset value; the sentinel is kept.
module decimal_text_to_int32_parser (
  input  logic        clk,
  input  logic        rst_n,
  // input character stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] character
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [31:0] parsed_value, [34:32] status,
                                   // [35] sentinel_hit, [39:36] zero
  // sentinel write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data     // [31:0] sentinel_value
);
  import dtoi_pkg::*;

  // input register
  logic              s1_valid_r, s1_valid_nxt;
  logic [CHAR_W-1:0] s1_char_r,  s1_char_nxt;
  // parse state
  parse_state_t      state_r,    state_nxt;
  // output register
  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r,   out_res_nxt;
  // sentinel
  logic [VAL_W-1:0]  sentinel_r,  sentinel_nxt;

  logic          s1_term;
  logic          s1_adv;
  logic          in_fire;
  parse_state_t  step_state;
  result_t       term_res;

  dtoi_step u_step (
    .state_i (state_r),
    .char_i  (s1_char_r),
    .state_o (step_state)
  );

  dtoi_result u_result (
    .state_i    (state_r),
    .sentinel_i (sentinel_r),
    .result_o   (term_res)
  );

  assign s1_term = (s1_char_r == CH_NUL);
  // ordinary characters always advance; a terminator needs a free output slot
  assign s1_adv  = s1_valid_r && (!s1_term || !out_valid_r || out_tready);

  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_char_nxt  = s1_char_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
      s1_char_nxt  = in_tdata;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (s1_adv) begin
      state_nxt = s1_term ? PARSE_RST : step_state;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (s1_adv && s1_term) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = term_res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign sentinel_nxt = (cfg_valid && cfg_ready) ? cfg_data : sentinel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      state_r     <= PARSE_RST;
      out_valid_r <= 1'b0;
      sentinel_r  <= SENTINEL_RST;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sentinel_r  <= sentinel_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    s1_char_r <= s1_char_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.hit, out_res_r.status, out_res_r.value};

`ifndef SYNTHESIS
  // a failed parse never reports a value or a sentinel hit
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.status != ST_OK)) |->
      ((out_res_r.value == '0) && !out_res_r.hit))
    else $error("non-ok result carries value or hit");

  // a consumed terminator returns the parse state to its reset value
  a_term_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_term) |=> ((state_r.phase == PH_LEAD) && (state_r.mag == '0)
      && !state_r.neg && (state_r.err == ST_OK)))
    else $error("parse state not cleared after terminator");

  // a stalled terminator stays in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && (s1_char_r == CH_NUL)))
    else $error("stalled terminator lost");

  // error phase and error code agree
  a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_ERROR) == (state_r.err != ST_OK))
    else $error("error code inconsistent with phase");

  // accumulated magnitude never exceeds the bound for its sign
  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({4'b0000, state_r.mag} <= (state_r.neg ? NEG_LIMIT : POS_LIMIT)))
    else $error("magnitude beyond signed bound");
`endif

endmodule

// ----- rtl/dtoi_step.sv -----
// Next-state logic of the parser: one non-terminator character per call.
// Depends on dtoi_pkg.
module dtoi_step (
  input  dtoi_pkg::parse_state_t  state_i,
  input  logic [7:0]              char_i,
  output dtoi_pkg::parse_state_t  state_o
);
  import dtoi_pkg::*;

  logic [CHAR_W-1:0] digit_full;
  logic [ACC_W-1:0]  acc;
  logic              c_space;
  logic              c_digit;
  parse_state_t      took;

  assign c_space    = is_space(char_i);
  assign c_digit    = is_digit(char_i);
  assign digit_full = char_i - CH_ZERO;

  // mag * 10 + digit as shifts and adds
  assign acc = {1'b0, state_i.mag, 3'b000} + {3'b000, state_i.mag, 1'b0}
             + {{(ACC_W-4){1'b0}}, digit_full[3:0]};

  always_comb begin
    took = state_i;
    if (!state_i.neg && (acc > POS_LIMIT)) begin
      took.phase = PH_ERROR;
      took.err   = ST_OVERFLOW;
    end else if (state_i.neg && (acc > NEG_LIMIT)) begin
      took.phase = PH_ERROR;
      took.err   = ST_UNDERFLOW;
    end else begin
      took.phase = PH_DIGITS;
      took.mag   = acc[VAL_W-1:0];
    end
  end

  always_comb begin
    state_o = state_i;
    unique case (state_i.phase)
      PH_LEAD: begin
        if (c_space) begin
          state_o = state_i;
        end else if ((char_i == CH_PLUS) || (char_i == CH_MINUS)) begin
          state_o.neg   = (char_i == CH_MINUS);
          state_o.phase = PH_SIGN;
        end else if (c_digit) begin
          state_o = took;
        end else begin
          state_o.phase = PH_ERROR;
          state_o.err   = ST_INVALID;
        end
      end
      PH_SIGN: begin
        if (c_digit) begin
          state_o = took;
        end else begin
          state_o.phase = PH_ERROR;
          state_o.err   = ST_INVALID;
        end
      end
      PH_DIGITS: begin
        if (c_digit) begin
          state_o = took;
        end else if (c_space) begin
          state_o.phase = PH_TRAIL;
        end else begin
          state_o.phase = PH_ERROR;
          state_o.err   = ST_INVALID;
        end
      end
      PH_TRAIL: begin
        if (!c_space) begin
          state_o.phase = PH_ERROR;
          state_o.err   = ST_INVALID;
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

// ----- rtl/dtoi_result.sv -----
// Result formation on the terminator: status, signed value, sentinel bump.
// Depends on dtoi_pkg.
module dtoi_result (
  input  dtoi_pkg::parse_state_t  state_i,
  input  logic [31:0]             sentinel_i,
  output dtoi_pkg::result_t       result_o
);
  import dtoi_pkg::*;

  logic [VAL_W-1:0] signed_val;

  assign signed_val = state_i.neg ? (VAL_W'(0) - state_i.mag) : state_i.mag;

  always_comb begin
    result_o = '{value: '0, status: ST_OK, hit: 1'b0};
    unique case (state_i.phase)
      PH_LEAD: begin
        result_o.status = ST_EMPTY;
      end
      PH_SIGN: begin
        result_o.status = ST_INVALID;
      end
      PH_DIGITS, PH_TRAIL: begin
        if (signed_val == sentinel_i) begin
          result_o.value = signed_val + VAL_W'(1);
          result_o.hit   = 1'b1;
        end else begin
          result_o.value = signed_val;
        end
      end
      default: begin
        result_o.status = (state_i.err == ST_OK) ? ST_INVALID : state_i.err;
      end
    endcase
  end

endmodule
